// ----- hdl/ssme_pkg.sv -----
// Shared types and constants for the sorted set merge engine.
package ssme_pkg;

   localparam int SET_DEPTH   = 32;
   localparam int IDX_W       = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int CNT_W       = $clog2(SET_DEPTH + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [1:0] OP_START         = 2'd2;

   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_MERGE  = 2'd2;

   localparam logic MODE_UNION    = 1'b0;
   localparam logic MODE_SYM_DIFF = 1'b1;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_res;
      logic               present;
      logic               last;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
      logic               mode;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

endpackage

// ----- hdl/ssme_front.sv -----
// Front end: accepts requests, classifies them and queues commands for the back end.
module ssme_front import ssme_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  logic         csr_valid,
   input  logic         csr_data,
   output cmd_link_type cmd_link,
   input  logic         cmd_pop
);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                mode_ff, mode_in;
   logic                accept;
   logic                push;
   cmd_type             new_cmd;

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;

   // The unused op code is accepted and dropped here.
   always_comb begin
      new_cmd.value = req_data.value;
      new_cmd.mode  = mode_ff;
      push          = 1'b0;
      case (req_data.op)
         OP_APPEND_FIRST: begin
            new_cmd.kind = CMD_LOAD_A;
            push         = accept;
         end
         OP_APPEND_SECOND: begin
            new_cmd.kind = CMD_LOAD_B;
            push         = accept;
         end
         OP_START: begin
            new_cmd.kind = CMD_MERGE;
            push         = accept;
         end
         default: begin
            new_cmd.kind = CMD_LOAD_A;
         end
      endcase
   end

   always_comb begin
      mode_in   = csr_valid ? csr_data : mode_ff;
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         mode_ff   <= MODE_UNION;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         mode_ff   <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_link.valid = (count_ff != '0);
   assign cmd_link.cmd   = queue_ff[rd_ptr_ff];

endmodule

// ----- hdl/ssme_back.sv -----
// Back end: set stores, two-pointer merge sequencer and the result register.
module ssme_back import ssme_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_link_type cmd_link,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PRIME = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   logic signed [31:0] mem_a [SET_DEPTH];
   logic signed [31:0] mem_b [SET_DEPTH];

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]   cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic               drop_ff, drop_in;
   logic               mode_ff, mode_in;
   logic               pend_valid_ff, pend_valid_in;
   logic signed [31:0] pend_value_ff, pend_value_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_data_ff, out_data_in;
   logic signed [31:0] a_rd_ff;
   logic signed [31:0] b_rd_ff;

   logic               we_a;
   logic               we_b;
   logic               a_ok;
   logic               b_ok;
   logic               out_free;
   logic               out_load;
   logic               emit;
   logic signed [31:0] emit_val;
   logic               finish;

   assign a_ok     = (i_ff < cnt_a_ff);
   assign b_ok     = (j_ff < cnt_b_ff);
   assign out_free = !out_valid_ff || rsp_ready;

   // Merge decision for one step of the two pointers.
   always_comb begin
      i_in     = i_ff;
      j_in     = j_ff;
      emit     = 1'b0;
      emit_val = a_rd_ff;
      finish   = 1'b0;
      if (state_ff == ST_RUN && out_free) begin
         if (a_ok && b_ok) begin
            if (mode_ff == MODE_UNION) begin
               if (b_rd_ff < a_rd_ff) begin
                  emit     = 1'b1;
                  emit_val = b_rd_ff;
                  j_in     = j_ff + CNT_W'(1);
               end else begin
                  emit = 1'b1;
                  i_in = i_ff + CNT_W'(1);
                  if (!(a_rd_ff < b_rd_ff)) begin
                     j_in = j_ff + CNT_W'(1);
                  end
               end
            end else begin
               if (a_rd_ff < b_rd_ff) begin
                  emit = 1'b1;
                  i_in = i_ff + CNT_W'(1);
               end else if (b_rd_ff < a_rd_ff) begin
                  emit     = 1'b1;
                  emit_val = b_rd_ff;
                  j_in     = j_ff + CNT_W'(1);
               end else begin
                  // Matched pair cancels out.
                  i_in = i_ff + CNT_W'(1);
                  j_in = j_ff + CNT_W'(1);
               end
            end
         end else if (a_ok) begin
            emit = 1'b1;
            i_in = i_ff + CNT_W'(1);
         end else if (b_ok) begin
            emit     = 1'b1;
            emit_val = b_rd_ff;
            j_in     = j_ff + CNT_W'(1);
         end else begin
            finish = 1'b1;
            i_in   = '0;
            j_in   = '0;
         end
      end
   end

   // Sequencer, counters and the one-deep holding slot that lets the final
   // result carry its last flag.
   always_comb begin
      state_in      = state_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      drop_in       = drop_ff;
      mode_in       = mode_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      cmd_pop       = 1'b0;
      we_a          = 1'b0;
      we_b          = 1'b0;
      out_load      = 1'b0;
      out_data_in   = out_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_link.valid) begin
               cmd_pop = 1'b1;
               case (cmd_link.cmd.kind)
                  CMD_LOAD_A: begin
                     if (cnt_a_ff < CNT_W'(SET_DEPTH)) begin
                        we_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + CNT_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  CMD_LOAD_B: begin
                     if (cnt_b_ff < CNT_W'(SET_DEPTH)) begin
                        we_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + CNT_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  CMD_MERGE: begin
                     mode_in       = cmd_link.cmd.mode;
                     pend_valid_in = 1'b0;
                     state_in      = ST_PRIME;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PRIME: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (emit) begin
               pend_valid_in = 1'b1;
               pend_value_in = emit_val;
               if (pend_valid_ff) begin
                  out_load              = 1'b1;
                  out_data_in.value_res = pend_value_ff;
                  out_data_in.present   = 1'b1;
                  out_data_in.last      = 1'b0;
                  out_data_in.overflow  = drop_ff;
               end
            end else if (finish) begin
               out_load              = 1'b1;
               out_data_in.value_res = pend_valid_ff ? pend_value_ff : 32'sd0;
               out_data_in.present   = pend_valid_ff;
               out_data_in.last      = 1'b1;
               out_data_in.overflow  = drop_ff;
               pend_valid_in         = 1'b0;
               cnt_a_in              = '0;
               cnt_b_in              = '0;
               drop_in               = 1'b0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         drop_ff       <= 1'b0;
         mode_ff       <= MODE_UNION;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         drop_ff       <= drop_in;
         mode_ff       <= mode_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
      out_data_ff   <= out_data_in;
   end

   // Each store is read at the next pointer value, so the registered data
   // matches the current pointer.
   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[cnt_a_ff[IDX_W-1:0]] <= cmd_link.cmd.value;
      end
      a_rd_ff <= mem_a[i_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[cnt_b_ff[IDX_W-1:0]] <= cmd_link.cmd.value;
      end
      b_rd_ff <= mem_b[j_in[IDX_W-1:0]];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- hdl/sorted_set_merge_engine_unit.sv -----
// Top level of the sorted set merge engine: front end, command queue and back end.
// Usage:
// Requests arrive on req_valid/req_ready/req_data. An append op writes one value
// into the first or second set store; a start op merges both stores and sends
// the sorted result on rsp_valid/rsp_ready/rsp_data, one response per value,
// with last set on the final one. An empty result gives one response with
// present low. The csr port writes the one-bit mode (union or symmetric
// difference); it is always ready. The user must write it only while the
// block is idle; the block does not enforce this. The front end holds a
// two-entry command queue, so requests keep flowing while the back end works.
// An append is written to its store from the idle state. A start passes a
// prime state while the first store entries are fetched, then takes one merge
// step per cycle while the output is free, at most one result per step, and a
// final step to close the run. The step rate is set by the single read port
// of each store. When the receiver stalls, the result register holds and the
// merge pauses. Synchronous reset empties the queue, clears both counts, the
// drop flag and the mode; store contents are undefined until written.
module sorted_set_merge_engine_unit import ssme_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   cmd_link_type cmd_link;
   logic         cmd_pop;

   assign csr_ready = 1'b1;

   ssme_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd_link  (cmd_link),
      .cmd_pop   (cmd_pop)
   );

   ssme_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_link  (cmd_link),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // An empty-result response always closes its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.present |-> rsp_data.last)
      else $error("empty-result response without last");

   // The back end never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_link.valid)
      else $error("command popped from empty queue");

   // A stalled response stays valid and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for sorted_set_merge_engine_unit: directed and random merges.
`timescale 1ns / 1ps
module tb;
   import ssme_pkg::*;

   localparam logic [1:0]         OP_UNUSED     = 2'd3;
   localparam int                 SETTLE_CYCLES = 16;
   localparam int                 CYCLE_LIMIT   = 400000;
   localparam logic signed [31:0] VAL_MIN       = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX       = 32'sh7fff_ffff;

   typedef enum logic [1:0] {STEP_REQUEST, STEP_MODE_WRITE, STEP_DRAIN} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      logic          mode;
      req_type       req;
   } step_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;

   step_type backlog[$];
   rsp_type  pending_results[$];
   logic     results_outstanding = 1'b0;

   // Local copy of the block's state.
   logic signed [31:0] set_a_mem [SET_DEPTH];
   logic signed [31:0] set_b_mem [SET_DEPTH];
   int                 set_a_count = 0;
   int                 set_b_count = 0;
   logic               set_dropped = 1'b0;
   logic               merge_mode  = MODE_UNION;
   rsp_type            held_result;
   logic               result_held;

   logic signed [31:0] value_pool [16];
   int                 pool_size;

   int planned_items     = 0;
   int requests_accepted = 0;
   int results_checked   = 0;
   int merges_seen       = 0;
   int symdiff_merges    = 0;
   int empty_results     = 0;
   int overflow_results  = 0;
   int mismatches        = 0;
   int cycle_count       = 0;
   int idle_cycles       = 0;
   int gap_left          = 0;
   int burst_left        = 1;
   int stall_left        = 0;

   sorted_set_merge_engine_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
   endtask

   // Each emitted value is held back one step so the final one can carry last.
   task automatic emit_result(input logic signed [31:0] v, input logic present);
      if (result_held) begin
         pending_results.push_back(held_result);
      end
      held_result.value_res = v;
      held_result.present   = present;
      held_result.last      = 1'b0;
      held_result.overflow  = set_dropped;
      result_held = 1'b1;
   endtask

   task automatic apply_request(input req_type r);
      int                 i;
      int                 j;
      logic signed [31:0] a;
      logic signed [31:0] b;
      case (r.op)
         OP_APPEND_FIRST: begin
            if (set_a_count < SET_DEPTH) begin
               set_a_mem[set_a_count] = r.value;
               set_a_count++;
            end else begin
               set_dropped = 1'b1;
            end
         end
         OP_APPEND_SECOND: begin
            if (set_b_count < SET_DEPTH) begin
               set_b_mem[set_b_count] = r.value;
               set_b_count++;
            end else begin
               set_dropped = 1'b1;
            end
         end
         OP_START: begin
            i = 0;
            j = 0;
            result_held = 1'b0;
            if (merge_mode == MODE_SYM_DIFF) begin
               symdiff_merges++;
            end
            while (i < set_a_count && j < set_b_count) begin
               a = set_a_mem[i];
               b = set_b_mem[j];
               if (merge_mode == MODE_UNION) begin
                  if (b < a) begin
                     emit_result(b, 1'b1);
                     j++;
                  end else begin
                     emit_result(a, 1'b1);
                     if (!(a < b)) j++;
                     i++;
                  end
               end else begin
                  if (a < b) begin
                     emit_result(a, 1'b1);
                     i++;
                  end else begin
                     // Equal heads cancel each other; otherwise the smaller second value goes out.
                     if (b < a) emit_result(b, 1'b1);
                     else i++;
                     j++;
                  end
               end
            end
            while (i < set_a_count) begin
               emit_result(set_a_mem[i], 1'b1);
               i++;
            end
            while (j < set_b_count) begin
               emit_result(set_b_mem[j], 1'b1);
               j++;
            end
            if (!result_held) begin
               emit_result('0, 1'b0);
            end
            held_result.last = 1'b1;
            pending_results.push_back(held_result);
            set_a_count = 0;
            set_b_count = 0;
            set_dropped = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic push_step(input step_kind_type kind, input logic mode, input logic [1:0] op,
                            input logic signed [31:0] v);
      step_type s;
      s.kind      = kind;
      s.mode      = mode;
      s.req.op    = op;
      s.req.value = v;
      backlog.push_back(s);
      if (kind == STEP_REQUEST && op != OP_UNUSED) begin
         planned_items++;
      end
   endtask

   task automatic push_req(input logic [1:0] op, input logic signed [31:0] v);
      push_step(STEP_REQUEST, 1'b0, op, v);
   endtask

   task automatic load_list(input logic [1:0] op, input int count, input bit sorted);
      logic signed [31:0] vals [40];
      logic signed [31:0] t;
      int                 m;
      for (int k = 0; k < count; k++) begin
         vals[k] = value_pool[$urandom_range(0, pool_size - 1)];
      end
      if (sorted) begin
         for (int k = 1; k < count; k++) begin
            t = vals[k];
            m = k;
            while (m > 0 && vals[m - 1] > t) begin
               vals[m] = vals[m - 1];
               m--;
            end
            vals[m] = t;
         end
      end
      for (int k = 0; k < count; k++) begin
         push_req(op, vals[k]);
      end
   endtask

   // One load-and-merge sequence. Values come from a small pool so that the
   // two lists share values and duplicates; a negative size means random.
   task automatic random_merge_set(input int force_a, input int force_b);
      int                 n_a;
      int                 n_b;
      int                 flavor;
      bit                 sorted;
      logic signed [31:0] base;
      pool_size = $urandom_range(1, 12);
      flavor    = $urandom_range(0, 2);
      base      = $urandom;
      for (int k = 0; k < pool_size; k++) begin
         if (flavor == 0) begin
            value_pool[k] = $urandom;
         end else if (flavor == 1) begin
            value_pool[k] = base + $urandom_range(0, 20);
         end else begin
            case ($urandom_range(0, 4))
               0: value_pool[k] = VAL_MIN;
               1: value_pool[k] = VAL_MAX;
               2: value_pool[k] = -1;
               3: value_pool[k] = 0;
               default: value_pool[k] = $urandom;
            endcase
         end
      end
      if (force_a >= 0) n_a = force_a;
      else n_a = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
      if (force_b >= 0) n_b = force_b;
      else n_b = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
      sorted = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 1)) begin
         load_list(OP_APPEND_FIRST, n_a, sorted);
         load_list(OP_APPEND_SECOND, n_b, sorted);
      end else begin
         load_list(OP_APPEND_SECOND, n_b, sorted);
         load_list(OP_APPEND_FIRST, n_a, sorted);
      end
      if ($urandom_range(0, 5) == 0) begin
         push_req(OP_UNUSED, $urandom);
      end
      push_req(OP_START, $urandom);
   endtask

   // Request and configuration driver.
   always @(posedge clock) begin : drive_requests
      logic     next_req_valid;
      logic     next_csr_valid;
      logic     next_csr_data;
      logic     req_done;
      logic     csr_done;
      req_type  next_req_data;
      step_type head;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         req_done = req_valid && req_ready;
         csr_done = csr_valid && csr_ready;
         if (req_valid || csr_valid || results_outstanding) idle_cycles = 0;
         else if (idle_cycles < SETTLE_CYCLES) idle_cycles++;
         next_req_valid = 1'b0;
         next_csr_valid = 1'b0;
         next_req_data  = req_data;
         next_csr_data  = csr_data;
         if ((req_valid && !req_done) || (csr_valid && !csr_done)) begin
            next_req_valid = req_valid;
            next_csr_valid = csr_valid;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (backlog.size() != 0) begin
            head = backlog[0];
            case (head.kind)
               STEP_REQUEST: begin
                  head = backlog.pop_front();
                  next_req_valid = 1'b1;
                  next_req_data  = head.req;
                  if (burst_left > 1) begin
                     burst_left--;
                  end else begin
                     burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                               : $urandom_range(1, 8);
                     gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                  end
               end
               STEP_MODE_WRITE: begin
                  // The block may still be finishing appends, so let it settle first.
                  if (!req_valid && !csr_valid && idle_cycles >= SETTLE_CYCLES) begin
                     head = backlog.pop_front();
                     next_csr_valid = 1'b1;
                     next_csr_data  = head.mode;
                  end
               end
               default: begin
                  if (!req_valid && !results_outstanding) begin
                     head = backlog.pop_front();
                  end
               end
            endcase
         end
         req_valid <= next_req_valid;
         req_data  <= next_req_data;
         csr_valid <= next_csr_valid;
         csr_data  <= next_csr_data;
      end
   end

   // Response checker; it also feeds accepted requests and mode writes to the predictor.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_data.last) merges_seen++;
            if (!rsp_data.present) empty_results++;
            if (rsp_data.overflow) overflow_results++;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf(
                  "unexpected result value_res=%0d present=%0b last=%0b overflow=%0b",
                  rsp_data.value_res, rsp_data.present, rsp_data.last, rsp_data.overflow));
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.value_res !== want.value_res || rsp_data.present !== want.present ||
                   rsp_data.last !== want.last || rsp_data.overflow !== want.overflow) begin
                  report_mismatch($sformatf(
                     {"result %0d expected %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                      " (value/present/last/ovf)"},
                     results_checked, want.value_res, want.present, want.last, want.overflow,
                     rsp_data.value_res, rsp_data.present, rsp_data.last, rsp_data.overflow));
               end
            end
            results_checked++;
         end
         if (req_valid && req_ready) begin
            requests_accepted++;
            apply_request(req_data);
         end
         if (csr_valid && csr_ready) begin
            merge_mode = csr_data;
         end
         results_outstanding <= (pending_results.size() != 0);
         // The stall pattern steps through none, short, long, alternating, chosen by cycle_count[9:8].
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (cycle_count[9:8])
               2'd0: rsp_ready <= 1'b1;
               2'd1: begin
                  if ($urandom_range(0, 3) == 0) begin
                     rsp_ready <= 1'b0;
                     stall_left = $urandom_range(0, 2);
                  end else begin
                     rsp_ready <= 1'b1;
                  end
               end
               2'd2: begin
                  if ($urandom_range(0, 9) == 0) begin
                     rsp_ready <= 1'b0;
                     stall_left = $urandom_range(4, 12);
                  end else begin
                     rsp_ready <= 1'b1;
                  end
               end
               default: rsp_ready <= cycle_count[0];
            endcase
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d results still expected.",
                  cycle_count, pending_results.size());
         $display("sorted_set_merge_engine_unit regression: fail");
         $finish;
      end
   end

   initial begin : run_regression
      int phase_start;
      // Union: empty stores, the unused op, extremes with matches, one list only.
      push_step(STEP_MODE_WRITE, MODE_UNION, OP_START, '0);
      push_req(OP_START, VAL_MAX);
      push_req(OP_UNUSED, VAL_MIN);
      push_req(OP_APPEND_FIRST, VAL_MIN);
      push_req(OP_APPEND_FIRST, -1);
      push_req(OP_APPEND_FIRST, 0);
      push_req(OP_APPEND_FIRST, VAL_MAX);
      push_req(OP_APPEND_SECOND, VAL_MIN);
      push_req(OP_APPEND_SECOND, 0);
      push_req(OP_APPEND_SECOND, 0);
      push_req(OP_APPEND_SECOND, 5);
      push_req(OP_START, 0);
      push_req(OP_APPEND_FIRST, 1);
      push_req(OP_APPEND_FIRST, 2);
      push_req(OP_START, -1);
      // Symmetric difference: duplicates against one copy, then a fully cancelled result.
      push_step(STEP_MODE_WRITE, MODE_SYM_DIFF, OP_START, '0);
      push_req(OP_APPEND_FIRST, VAL_MIN);
      push_req(OP_APPEND_FIRST, 3);
      push_req(OP_APPEND_FIRST, 3);
      push_req(OP_APPEND_FIRST, VAL_MAX);
      push_req(OP_APPEND_SECOND, 3);
      push_req(OP_APPEND_SECOND, VAL_MAX);
      push_req(OP_START, 0);
      push_req(OP_APPEND_FIRST, 7);
      push_req(OP_APPEND_SECOND, 7);
      push_req(OP_START, VAL_MIN);

      for (int ph = 0; ph < 4; ph++) begin
         if (ph > 0) begin
            push_step(STEP_MODE_WRITE, (ph % 2 == 1) ? MODE_UNION : MODE_SYM_DIFF, OP_START, '0);
         end
         phase_start = planned_items;
         // Each of the first two phases opens with a store overrun.
         random_merge_set((ph == 0) ? 34 : -1, (ph == 1) ? 35 : -1);
         while (planned_items - phase_start < 45) begin
            random_merge_set(-1, -1);
            if ($urandom_range(0, 4) == 0) begin
               push_step(STEP_DRAIN, 1'b0, OP_START, '0);
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (backlog.size() != 0 || req_valid || csr_valid || results_outstanding ||
             pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests; checked %0d results from %0d merges, %0d of them symmetric.",
               requests_accepted, results_checked, merges_seen, symdiff_merges);
      $display("Empty results: %0d, results with overflow set: %0d, mismatches: %0d.",
               empty_results, overflow_results, mismatches);
      if (mismatches == 0) begin
         $display("sorted_set_merge_engine_unit regression: pass");
      end else begin
         $display("sorted_set_merge_engine_unit regression: fail");
      end
      $finish;
   end

endmodule
